/* design/stxrx_pkg.sv */
// Shared types, constants and the CRC-8 step for the STX/ETX frame receiver.
`timescale 1ns / 1ps

package stxrx_pkg;

	// Reflected CRC-8 polynomial and bit mask
	localparam logic [7:0] CRC_POLY = 8'h8C;
	localparam logic [7:0] CRC_LSB  = 8'h01;

	// Configuration register indexes
	localparam logic [1:0] REG_START_CODE = 2'd0;
	localparam logic [1:0] REG_END_CODE   = 2'd1;
	localparam logic [1:0] REG_MAX_LENGTH = 2'd2;

	// Register reset values
	localparam logic [7:0] START_CODE_RST = 8'h02;
	localparam logic [7:0] END_CODE_RST   = 8'h03;
	localparam logic [7:0] MAX_LENGTH_RST = 8'd64;

	// Result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_FINISH  = 1'b1;

	// Frame finish status
	typedef enum logic [1:0] {
		STATUS_GOOD     = 2'd0,
		STATUS_MISMATCH = 2'd1,
		STATUS_OVERFLOW = 2'd2
	} status_t;

	// One result word
	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		status_t     frame_status;
		logic [7:0]  frame_length;
		logic [7:0]  computed_crc;
	} result_t;

	// Fold one byte into the running CRC, LSB first
	function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		logic [7:0] b;
		logic       mix;
		c = crc;
		b = data;
		for (int i = 0; i < 8; i++) begin
			mix = ((c ^ b) & CRC_LSB) != 8'd0;
			c = c >> 1;
			if (mix) begin
				c = c ^ CRC_POLY;
			end
			b = b >> 1;
		end
		return c;
	endfunction

endpackage

/* design/stx_etx_frame_receiver_crc8.sv */
// Top level of the STX/ETX frame receiver with CRC-8 check.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid, in_stall, rx_byte) takes one received serial byte
//   per word. Bytes before the start code are dropped. Inside a frame each
//   payload byte comes out as a kind 0 word with the running length and CRC;
//   the byte after the end code is the checksum and closes the frame with a
//   kind 1 word (good or CRC mismatch); an over-long frame ends in overflow.
//   Output channel (out_valid, out_stall) carries the result fields.
//   Each result is registered into the output word, or the skid register.
//   Throughput: one byte per cycle while in_stall is low; the CRC step is an
//   unrolled 8-bit fold in the state update path.
//   When the receiver stalls, the output word holds and one more result
//   lands in a skid register; in_stall rises only while that skid is full.
//   Bytes that give no result are taken as long as in_stall is low.
//   Reset (arst_n low) returns the receiver to waiting for a start code,
//   empties the output and loads start 0x02, end 0x03, max length 64.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
//   and are meant for idle periods; unknown indexes are ignored.

module stx_etx_frame_receiver_crc8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       kind,
	output logic [7:0] payload_byte,
	output logic [1:0] frame_status,
	output logic [7:0] frame_length,
	output logic [7:0] computed_crc
);

	logic [7:0] start_code_q;
	logic [7:0] end_code_q;
	logic [7:0] max_length_q;

	logic       in_frame_q;
	logic       expect_chk_q;
	logic [7:0] crc_q;
	logic [7:0] count_q;

	logic       in_frame_d;
	logic       expect_chk_d;
	logic [7:0] crc_d;
	logic [7:0] count_d;

	logic                 res_v;
	stxrx_pkg::result_t   res;

	logic                 out_v_q;
	stxrx_pkg::result_t   out_q;
	logic                 skid_v_q;
	stxrx_pkg::result_t   skid_q;

	logic in_acc;
	logic out_take;

	assign in_stall = skid_v_q;
	assign in_acc   = in_valid && !in_stall;
	assign out_take = out_v_q && !out_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q <= stxrx_pkg::START_CODE_RST;
			end_code_q   <= stxrx_pkg::END_CODE_RST;
			max_length_q <= stxrx_pkg::MAX_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				stxrx_pkg::REG_START_CODE: start_code_q <= cfg_data;
				stxrx_pkg::REG_END_CODE:   end_code_q   <= cfg_data;
				stxrx_pkg::REG_MAX_LENGTH: max_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Frame parser: next state and result for the byte at the input
	always_comb begin
		in_frame_d   = in_frame_q;
		expect_chk_d = expect_chk_q;
		crc_d        = crc_q;
		count_d      = count_q;
		res_v        = 1'b0;
		res.kind         = stxrx_pkg::KIND_PAYLOAD;
		res.payload_byte = 8'd0;
		res.frame_status = stxrx_pkg::STATUS_GOOD;
		res.frame_length = count_q;
		res.computed_crc = crc_q;
		if (!in_frame_q) begin
			if (rx_byte == start_code_q) begin
				in_frame_d   = 1'b1;
				expect_chk_d = 1'b0;
				crc_d        = 8'd0;
				count_d      = 8'd0;
			end
		end else if (expect_chk_q) begin
			res_v            = 1'b1;
			res.kind         = stxrx_pkg::KIND_FINISH;
			res.frame_status = (rx_byte == crc_q) ? stxrx_pkg::STATUS_GOOD
			                                      : stxrx_pkg::STATUS_MISMATCH;
			in_frame_d   = 1'b0;
			expect_chk_d = 1'b0;
			crc_d        = 8'd0;
			count_d      = 8'd0;
		end else if (rx_byte == start_code_q) begin
			// restart: the open frame is dropped without a result
			expect_chk_d = 1'b0;
			crc_d        = 8'd0;
			count_d      = 8'd0;
		end else if (rx_byte == end_code_q) begin
			expect_chk_d = 1'b1;
		end else if (count_q >= max_length_q) begin
			res_v            = 1'b1;
			res.kind         = stxrx_pkg::KIND_FINISH;
			res.frame_status = stxrx_pkg::STATUS_OVERFLOW;
			in_frame_d   = 1'b0;
			expect_chk_d = 1'b0;
			crc_d        = 8'd0;
			count_d      = 8'd0;
		end else begin
			res_v            = 1'b1;
			res.payload_byte = rx_byte;
			crc_d            = stxrx_pkg::crc_fold(crc_q, rx_byte);
			count_d          = count_q + 8'd1;
			res.frame_length = count_d;
			res.computed_crc = crc_d;
		end
	end

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			expect_chk_q <= 1'b0;
			crc_q        <= 8'd0;
			count_q      <= 8'd0;
		end else if (in_acc) begin
			in_frame_q   <= in_frame_d;
			expect_chk_q <= expect_chk_d;
			crc_q        <= crc_d;
			count_q      <= count_d;
		end
	end

	// Output register and skid: valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_take) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= in_acc && res_v;
			end
		end else if (!out_v_q) begin
			out_v_q <= in_acc && res_v;
		end else if (in_acc && res_v) begin
			skid_v_q <= 1'b1;
		end
	end

	// Output register and skid: payload
	always_ff @(posedge clk) begin
		if (out_take && skid_v_q) begin
			out_q <= skid_q;
		end else if (out_take || !out_v_q) begin
			out_q <= res;
		end
		if (!out_take && out_v_q && !skid_v_q) begin
			skid_q <= res;
		end
	end

	assign out_valid    = out_v_q;
	assign kind         = out_q.kind;
	assign payload_byte = out_q.payload_byte;
	assign frame_status = out_q.frame_status;
	assign frame_length = out_q.frame_length;
	assign computed_crc = out_q.computed_crc;

	// Checks
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid word held while output empty");

	a_chk_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		expect_chk_q |-> in_frame_q)
		else $error("checksum armed outside a frame");

	a_payload_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.kind == stxrx_pkg::KIND_PAYLOAD)
		|-> (out_q.frame_status == stxrx_pkg::STATUS_GOOD && out_q.frame_length != 8'd0))
		else $error("payload word with status or zero length");

	a_finish_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.kind == stxrx_pkg::KIND_FINISH) |-> out_q.payload_byte == 8'd0)
		else $error("finish word carries payload byte");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && res_v && !out_v_q) |=> out_v_q)
		else $error("result lost on empty output");

endmodule

/* sim/stxrx_checker.sv */
// Checker for the STX/ETX frame receiver: predicts result words and compares them.
`timescale 1ns / 1ps

module stxrx_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic       kind,
	input  logic [7:0] payload_byte,
	input  logic [1:0] frame_status,
	input  logic [7:0] frame_length,
	input  logic [7:0] computed_crc,
	output int         errors,
	output int         pending,
	output int         checked
);

	// Mirror of the receiver's registers and frame state
	logic [7:0] start_code_q;
	logic [7:0] end_code_q;
	logic [7:0] max_len_q;
	logic       in_frame_q;
	logic       want_check_q;
	logic [7:0] crc_q;
	logic [7:0] count_q;

	// Words the receiver still owes, oldest first
	stxrx_pkg::result_t expected_words[$];

	initial begin
		errors = 0;
		pending = 0;
		checked = 0;
	end

	// Reflected CRC-8: xor the byte in whole, then shift out eight bits
	function automatic logic [7:0] crc8_maxim(input logic [7:0] acc, input logic [7:0] d);
		logic [7:0] r;
		r = acc ^ d;
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ stxrx_pkg::CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		errors++;
	endtask

	task automatic clear_frame();
		in_frame_q = 1'b0;
		want_check_q = 1'b0;
		crc_q = 8'h00;
		count_q = 8'h00;
	endtask

	task automatic push_finish(input stxrx_pkg::status_t st);
		stxrx_pkg::result_t w;
		w.kind = stxrx_pkg::KIND_FINISH;
		w.payload_byte = 8'h00;
		w.frame_status = st;
		w.frame_length = count_q;
		w.computed_crc = crc_q;
		expected_words.push_back(w);
	endtask

	// Work out what one accepted byte does to the frame state
	task automatic predict_frame_byte(input logic [7:0] b);
		stxrx_pkg::result_t w;
		if (!in_frame_q) begin
			if (b == start_code_q) begin
				clear_frame();
				in_frame_q = 1'b1;
			end
		end else if (want_check_q) begin
			// byte after the end code is the checksum, whatever its value
			push_finish((b == crc_q) ? stxrx_pkg::STATUS_GOOD : stxrx_pkg::STATUS_MISMATCH);
			clear_frame();
		end else if (b == start_code_q) begin
			// restart drops the open frame silently
			clear_frame();
			in_frame_q = 1'b1;
		end else if (b == end_code_q) begin
			want_check_q = 1'b1;
		end else if (count_q >= max_len_q) begin
			push_finish(stxrx_pkg::STATUS_OVERFLOW);
			clear_frame();
		end else begin
			crc_q = crc8_maxim(crc_q, b);
			count_q = count_q + 8'd1;
			w.kind = stxrx_pkg::KIND_PAYLOAD;
			w.payload_byte = b;
			w.frame_status = stxrx_pkg::STATUS_GOOD;
			w.frame_length = count_q;
			w.computed_crc = crc_q;
			expected_words.push_back(w);
		end
	endtask

	// Compare an accepted output word against the oldest expectation
	task automatic check_result_word();
		stxrx_pkg::result_t w;
		if (expected_words.size() == 0) begin
			report_mismatch($sformatf("unexpected word kind %0d byte %02h len %0d",
				kind, payload_byte, frame_length));
			return;
		end
		w = expected_words.pop_front();
		checked++;
		if (kind !== w.kind)
			report_mismatch($sformatf("kind got %0d want %0d", kind, w.kind));
		if (payload_byte !== w.payload_byte)
			report_mismatch($sformatf("payload_byte got %02h want %02h",
				payload_byte, w.payload_byte));
		if (frame_status !== w.frame_status)
			report_mismatch($sformatf("frame_status got %0d want %0d",
				frame_status, w.frame_status));
		if (frame_length !== w.frame_length)
			report_mismatch($sformatf("frame_length got %0d want %0d",
				frame_length, w.frame_length));
		if (computed_crc !== w.computed_crc)
			report_mismatch($sformatf("computed_crc got %02h want %02h",
				computed_crc, w.computed_crc));
	endtask

	// Output side first: a word leaving at this edge comes from an earlier byte
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q = stxrx_pkg::START_CODE_RST;
			end_code_q = stxrx_pkg::END_CODE_RST;
			max_len_q = stxrx_pkg::MAX_LENGTH_RST;
			clear_frame();
			expected_words.delete();
		end else begin
			if (out_valid && !out_stall)
				check_result_word();
			if (in_valid && !in_stall)
				predict_frame_byte(rx_byte);
			if (cfg_we) begin
				case (cfg_index)
					stxrx_pkg::REG_START_CODE: start_code_q = cfg_data;
					stxrx_pkg::REG_END_CODE:   end_code_q = cfg_data;
					stxrx_pkg::REG_MAX_LENGTH: max_len_q = cfg_data;
					default: ;
				endcase
			end
		end
		pending = expected_words.size();
	end

endmodule

/* sim/stx_etx_frame_receiver_crc8_tb.sv */
// Testbench top for the STX/ETX frame receiver: stimulus, register settings and verdict.
`timescale 1ns / 1ps

module stx_etx_frame_receiver_crc8_tb;

	localparam int BYTE_TARGET = 1450;
	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT = 28;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_stall;
	logic       kind;
	logic [7:0] payload_byte;
	logic [1:0] frame_status;
	logic [7:0] frame_length;
	logic [7:0] computed_crc;

	int errors;
	int pending;
	int checked;

	// Current register values as the stimulus sees them
	logic [7:0] cur_start;
	logic [7:0] cur_end;
	logic [7:0] cur_max;

	bit calm;
	int cycles;
	int bytes_sent;
	int settings;
	int n_good;
	int n_corrupt;
	int n_ovf;
	int n_cut;

	stx_etx_frame_receiver_crc8 i_dut (.*);

	stxrx_checker i_chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycle watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words still owed", cycles, pending);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Receiver stall, random except during the calm stretch
	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
	end

	// Offer one word and hold it until the receiver takes it
	task automatic send_byte(input logic [7:0] b);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Drop valid, let every owed word drain, then allow the pipe to go quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_setting(input logic [7:0] s, input logic [7:0] e, input logic [7:0] m);
		settle();
		write_reg(stxrx_pkg::REG_START_CODE, s);
		write_reg(stxrx_pkg::REG_END_CODE, e);
		write_reg(stxrx_pkg::REG_MAX_LENGTH, m);
		cur_start = s;
		cur_end = e;
		cur_max = m;
		settings++;
	endtask

	// Payload byte, mostly clear of the framing codes
	function automatic logic [7:0] pick_payload();
		logic [7:0] b;
		if ($urandom_range(0, 99) < 4)
			return 8'($urandom_range(0, 255));
		do
			b = 8'($urandom_range(0, 255));
		while (b == cur_start || b == cur_end);
		return b;
	endfunction

	// One frame: start, payload, then end code and checksum unless it overflows or is cut
	task automatic send_frame(input int len, input bit good, input bit cut);
		logic [7:0] crc;
		logic [7:0] b;
		crc = 8'h00;
		send_byte(cur_start);
		for (int i = 0; i < len; i++) begin
			b = pick_payload();
			send_byte(b);
			if (i < cur_max)
				crc = stxrx_pkg::crc_fold(crc, b);
		end
		if (cut) begin
			n_cut++;
			return;
		end
		if (len > cur_max) begin
			n_ovf++;
			return;
		end
		send_byte(cur_end);
		if (good) begin
			send_byte(crc);
			n_good++;
		end else begin
			send_byte(crc ^ 8'(1 << $urandom_range(0, 7)));
			n_corrupt++;
		end
	endtask

	initial begin
		int lim;
		int len;
		int r;
		int phase_end;
		logic [7:0] s;
		logic [7:0] e;
		logic [7:0] m;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = stxrx_pkg::REG_START_CODE;
		cfg_data = 8'h00;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		calm = 1'b0;
		bytes_sent = 0;
		settings = 0;
		n_good = 0;
		n_corrupt = 0;
		n_ovf = 0;
		n_cut = 0;
		cur_start = stxrx_pkg::START_CODE_RST;
		cur_end = stxrx_pkg::END_CODE_RST;
		cur_max = stxrx_pkg::MAX_LENGTH_RST;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: noise while idle, including a stray end code
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(stxrx_pkg::END_CODE_RST);
		// good frame with extreme payload values
		send_byte(stxrx_pkg::START_CODE_RST);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(stxrx_pkg::END_CODE_RST);
		send_byte(stxrx_pkg::crc_fold(stxrx_pkg::crc_fold(8'h00, 8'h00), 8'hFF));
		// bad checksum
		send_byte(stxrx_pkg::START_CODE_RST);
		send_byte(8'hA5);
		send_byte(stxrx_pkg::END_CODE_RST);
		send_byte(stxrx_pkg::crc_fold(8'h00, 8'hA5) ^ 8'hFF);
		// empty frame, checksum zero
		send_byte(stxrx_pkg::START_CODE_RST);
		send_byte(stxrx_pkg::END_CODE_RST);
		send_byte(8'h00);
		// restart mid-frame, then a checksum byte equal to the start code
		send_byte(stxrx_pkg::START_CODE_RST);
		send_byte(8'h5A);
		send_byte(stxrx_pkg::START_CODE_RST);
		send_byte(8'h3C);
		send_byte(stxrx_pkg::END_CODE_RST);
		send_byte(stxrx_pkg::START_CODE_RST);
		// overflow at length one, then at length zero
		apply_setting(stxrx_pkg::START_CODE_RST, stxrx_pkg::END_CODE_RST, 8'd1);
		send_byte(stxrx_pkg::START_CODE_RST);
		send_byte(8'h10);
		send_byte(8'h20);
		apply_setting(stxrx_pkg::START_CODE_RST, stxrx_pkg::END_CODE_RST, 8'd0);
		send_byte(stxrx_pkg::START_CODE_RST);
		send_byte(8'h77);

		// Random frames across a series of register settings
		for (int ph = 0; bytes_sent < BYTE_TARGET; ph++) begin
			case (ph)
				0: begin
					s = stxrx_pkg::START_CODE_RST;
					e = stxrx_pkg::END_CODE_RST;
					m = stxrx_pkg::MAX_LENGTH_RST;
				end
				1: begin s = 8'h00; e = 8'hFF; m = 8'd1; end
				2: begin s = 8'hFF; e = 8'h00; m = 8'd255; end
				3: begin s = 8'h7E; e = 8'h7E; m = 8'd8; end
				4: begin s = 8'h55; e = 8'hAA; m = 8'd0; end
				default: begin
					s = 8'($urandom_range(0, 255));
					e = ($urandom_range(0, 9) == 0) ? s : 8'($urandom_range(0, 255));
					r = $urandom_range(0, 19);
					m = (r == 0) ? 8'd255 : (r == 1) ? 8'd1 : 8'($urandom_range(1, 16));
				end
			endcase
			apply_setting(s, e, m);
			calm = (ph == 6 || ph == 7);

			// longest legal frame and the first one past it
			if (ph == 2) begin
				send_frame(255, 1'b1, 1'b0);
				send_frame(256, 1'b1, 1'b0);
			end

			phase_end = bytes_sent + 130;
			while (bytes_sent < phase_end) begin
				r = $urandom_range(0, 99);
				if (r < 12) begin
					repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
				end else begin
					lim = (cur_max < 12) ? cur_max : 12;
					len = $urandom_range(0, lim);
					if ($urandom_range(0, 9) == 0 && cur_max <= 64)
						len = cur_max + 1;
					send_frame(len, $urandom_range(0, 99) < 75,
						$urandom_range(0, 99) < 8);
				end
			end
		end
		calm = 1'b0;

		// Drain and finish
		settle();
		repeat (8) @(negedge clk);
		$display("Sent %0d bytes under %0d register settings; %0d result words compared.",
			bytes_sent, settings, checked);
		$display("Frames: %0d good checksum, %0d corrupted, %0d overflowed, %0d cut short.",
			n_good, n_corrupt, n_ovf, n_cut);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
